// ----- rtl/core/slr_pkg.sv -----
// Shared constants and types for the styled line rasterizer.
package slr_pkg;

    // Command codes carried in the action field
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Line style codes; the unused code draws as solid
    localparam logic [1:0] STYLE_SOLID  = 2'd0;
    localparam logic [1:0] STYLE_DOTTED = 2'd1;
    localparam logic [1:0] STYLE_DASHED = 2'd2;

    // Configuration register map
    localparam int unsigned CFG_IDX_BITS  = 4;
    localparam int unsigned CFG_DATA_BITS = 4;
    localparam logic [CFG_IDX_BITS-1:0] REG_DASH_PERIOD = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DASH_ON     = 4'd1;

    // Register reset values
    localparam logic [CFG_DATA_BITS-1:0] DASH_PERIOD_RST = 4'd10;
    localparam logic [CFG_DATA_BITS-1:0] DASH_ON_RST     = 4'd5;

    // Walker status seen by the top level
    typedef struct packed {
        logic busy;       // a line has pixels still to give
        logic step_idle;  // a step beat was taken with no line active
    } slr_status_t;

endpackage

// ----- rtl/core/slr_if.sv -----
// Channel interfaces: command input, pixel output and register writes.
interface slr_cmd_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [1:0]                   line_style;

    modport source (output valid, action, start_x, start_y, end_x, end_y, line_style,
                    input ready);
    modport sink   (input valid, action, start_x, start_y, end_x, end_y, line_style,
                    output ready);
endinterface

interface slr_pixel_if #(parameter int COORD_BITS = 12);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         visible;
    logic                         last_pixel;

    modport source (output valid, pixel_x, pixel_y, visible, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, visible, last_pixel, output ready);
endinterface

interface slr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [slr_pkg::CFG_IDX_BITS-1:0]  index;
    logic [slr_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/slr_setup.sv -----
// Line setup: deltas, octant, initial decision value and pixel count.
module slr_setup #(
    parameter int COORD_BITS = 12
) (
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic                  step_x_neg,
    output logic                  step_y_neg,
    output logic                  x_major,
    output logic [COORD_BITS+1:0] err_init,
    output logic [COORD_BITS:0]   inc_axial,
    output logic [COORD_BITS+1:0] inc_diag,
    output logic [COORD_BITS:0]   pixel_count
);

    logic [COORD_BITS:0]   dx;
    logic [COORD_BITS:0]   dy;
    logic [COORD_BITS:0]   dx_mag;
    logic [COORD_BITS:0]   dy_mag;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;
    logic [COORD_BITS-1:0] major;
    logic [COORD_BITS-1:0] minor;
    logic [COORD_BITS+1:0] diff;

    // Signed deltas, one bit wider than a coordinate
    assign dx = {end_x[COORD_BITS-1], end_x} - {start_x[COORD_BITS-1], start_x};
    assign dy = {end_y[COORD_BITS-1], end_y} - {start_y[COORD_BITS-1], start_y};

    assign step_x_neg = dx[COORD_BITS];
    assign step_y_neg = dy[COORD_BITS];

    // Magnitudes always fit a coordinate's width
    assign dx_mag = step_x_neg ? (~dx + 1'b1) : dx;
    assign dy_mag = step_y_neg ? (~dy + 1'b1) : dy;
    assign abs_dx = dx_mag[COORD_BITS-1:0];
    assign abs_dy = dy_mag[COORD_BITS-1:0];

    // A tie is y-major
    assign x_major = abs_dx > abs_dy;
    assign major   = x_major ? abs_dx : abs_dy;
    assign minor   = x_major ? abs_dy : abs_dx;

    // Decision value and its two increments
    assign err_init    = {1'b0, minor, 1'b0} - {2'b00, major};
    assign diff        = {2'b00, minor} - {2'b00, major};
    assign inc_diag    = {diff[COORD_BITS:0], 1'b0};
    assign inc_axial   = {minor, 1'b0};
    assign pixel_count = {1'b0, major} + {{COORD_BITS{1'b0}}, 1'b1};

endmodule

// ----- rtl/core/slr_walker.sv -----
// Line walker: Bresenham state, style pattern and the pixel output register.
module slr_walker #(
    parameter int COORD_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command beat
    input  logic                                in_fire,
    input  logic                                in_action,
    input  logic [COORD_BITS-1:0]               in_start_x,
    input  logic [COORD_BITS-1:0]               in_start_y,
    input  logic [1:0]                          in_style,
    output logic                                in_ready,
    // setup results
    input  logic                                su_step_x_neg,
    input  logic                                su_step_y_neg,
    input  logic                                su_x_major,
    input  logic [COORD_BITS+1:0]               su_err_init,
    input  logic [COORD_BITS:0]                 su_inc_axial,
    input  logic [COORD_BITS+1:0]               su_inc_diag,
    input  logic [COORD_BITS:0]                 su_pixel_count,
    // pattern registers
    input  logic [slr_pkg::CFG_DATA_BITS-1:0]   dash_period,
    input  logic [slr_pkg::CFG_DATA_BITS-1:0]   dash_on_length,
    // pixel beat
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [COORD_BITS-1:0]               out_x,
    output logic [COORD_BITS-1:0]               out_y,
    output logic                                out_visible,
    output logic                                out_last,
    output slr_pkg::slr_status_t                status
);

    localparam int PW = slr_pkg::CFG_DATA_BITS;

    logic [COORD_BITS-1:0] cur_x_reg,   cur_x_next;
    logic [COORD_BITS-1:0] cur_y_reg,   cur_y_next;
    logic                  x_neg_reg,   x_neg_next;
    logic                  y_neg_reg,   y_neg_next;
    logic                  x_major_reg, x_major_next;
    logic [COORD_BITS+1:0] err_reg,     err_next;
    logic [COORD_BITS:0]   inc_a_reg,   inc_a_next;
    logic [COORD_BITS+1:0] inc_d_reg,   inc_d_next;
    logic [COORD_BITS:0]   left_reg,    left_next;
    logic [PW-1:0]         pat_reg,     pat_next;
    logic [1:0]            style_reg,   style_next;

    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_x_reg;
    logic [COORD_BITS-1:0] out_y_reg;
    logic                  out_vis_reg;
    logic                  out_last_reg;

    logic                  busy;
    logic                  do_start;
    logic                  do_pixel;
    logic                  err_ge;
    logic                  vis;
    logic                  last;
    logic                  move_x;
    logic                  move_y;
    logic [COORD_BITS-1:0] x_inc;
    logic [COORD_BITS-1:0] y_inc;
    logic [PW:0]           pat_inc;

    // Accept while the output slot is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;
    assign busy     = left_reg != '0;
    assign do_start = in_fire && (in_action == slr_pkg::ACT_START);
    assign do_pixel = in_fire && (in_action == slr_pkg::ACT_STEP) && busy;

    // Style decode for the current pixel
    always_comb
    begin
        unique case (style_reg)
            slr_pkg::STYLE_DOTTED: vis = !pat_reg[0];
            slr_pkg::STYLE_DASHED: vis = pat_reg < dash_on_length;
            default:               vis = 1'b1;
        endcase
    end

    assign last = left_reg == {{COORD_BITS{1'b0}}, 1'b1};

    // One Bresenham step: major axis always, minor axis when the error is non-negative
    assign err_ge  = !err_reg[COORD_BITS+1];
    assign move_x  = x_major_reg || err_ge;
    assign move_y  = !x_major_reg || err_ge;
    assign x_inc   = x_neg_reg ? {COORD_BITS{1'b1}} : {{(COORD_BITS-1){1'b0}}, 1'b1};
    assign y_inc   = y_neg_reg ? {COORD_BITS{1'b1}} : {{(COORD_BITS-1){1'b0}}, 1'b1};
    assign pat_inc = {1'b0, pat_reg} + {{PW{1'b0}}, 1'b1};

    // Line state next values
    always_comb
    begin
        cur_x_next   = cur_x_reg;
        cur_y_next   = cur_y_reg;
        x_neg_next   = x_neg_reg;
        y_neg_next   = y_neg_reg;
        x_major_next = x_major_reg;
        err_next     = err_reg;
        inc_a_next   = inc_a_reg;
        inc_d_next   = inc_d_reg;
        left_next    = left_reg;
        pat_next     = pat_reg;
        style_next   = style_reg;
        if (do_start)
        begin
            cur_x_next   = in_start_x;
            cur_y_next   = in_start_y;
            x_neg_next   = su_step_x_neg;
            y_neg_next   = su_step_y_neg;
            x_major_next = su_x_major;
            err_next     = su_err_init;
            inc_a_next   = su_inc_axial;
            inc_d_next   = su_inc_diag;
            left_next    = su_pixel_count;
            pat_next     = '0;
            style_next   = in_style;
        end
        else if (do_pixel)
        begin
            if (move_x)
            begin
                cur_x_next = cur_x_reg + x_inc;
            end
            if (move_y)
            begin
                cur_y_next = cur_y_reg + y_inc;
            end
            err_next  = err_ge ? (err_reg + inc_d_reg) : (err_reg + {1'b0, inc_a_reg});
            left_next = left_reg - {{COORD_BITS{1'b0}}, 1'b1};
            pat_next  = (pat_inc >= {1'b0, dash_period}) ? '0 : pat_inc[PW-1:0];
        end
    end

    // Output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (do_pixel)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            x_neg_reg     <= 1'b0;
            y_neg_reg     <= 1'b0;
            x_major_reg   <= 1'b0;
            err_reg       <= '0;
            inc_a_reg     <= '0;
            inc_d_reg     <= '0;
            left_reg      <= '0;
            pat_reg       <= '0;
            style_reg     <= slr_pkg::STYLE_SOLID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            x_neg_reg     <= x_neg_next;
            y_neg_reg     <= y_neg_next;
            x_major_reg   <= x_major_next;
            err_reg       <= err_next;
            inc_a_reg     <= inc_a_next;
            inc_d_reg     <= inc_d_next;
            left_reg      <= left_next;
            pat_reg       <= pat_next;
            style_reg     <= style_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pixel payload, loaded with the current pixel before it advances
    always_ff @(posedge clk)
    begin
        if (do_pixel)
        begin
            out_x_reg    <= cur_x_reg;
            out_y_reg    <= cur_y_reg;
            out_vis_reg  <= vis;
            out_last_reg <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_visible = out_vis_reg;
    assign out_last    = out_last_reg;

    assign status.busy      = busy;
    assign status.step_idle = in_fire && (in_action == slr_pkg::ACT_STEP) && !busy;

endmodule

// ----- rtl/core/styled_line_rasterizer.sv -----
// Styled line rasterizer top level: register file, setup and line walker.
//
//  channel | dir | beat contents                                      | accepted when
//  cmd     | in  | action, start_x, start_y, end_x, end_y, line_style | valid & ready
//  pixel   | out | pixel_x, pixel_y, visible, last_pixel              | valid & ready
//  cfg     | in  | index, data (0 dash_period, 1 dash_on_length)      | valid & ready
//
// One command beat per clock while cmd.ready is high; a step beat's pixel appears
// in the next cycle from the output register. Setup and each step are combinational
// adds and compares between the line state registers and the output register.
// cmd.ready is low only while a pixel sits in the output register and the
// sink stalls it. cfg.ready is always high. Reset clears the line (idle)
// and loads dash_period 10, dash_on_length 5; no clearing pass is needed.
module styled_line_rasterizer #(
    parameter int COORD_BITS = 12
) (
    input  logic          clk,
    input  logic          rst_n,
    slr_cmd_if.sink       cmd,
    slr_pixel_if.source   pixel,
    slr_cfg_if.sink       cfg
);

    logic [slr_pkg::CFG_DATA_BITS-1:0] dash_period_reg, dash_period_next;
    logic [slr_pkg::CFG_DATA_BITS-1:0] dash_on_reg,     dash_on_next;

    logic                  su_x_neg;
    logic                  su_y_neg;
    logic                  su_x_major;
    logic [COORD_BITS+1:0] su_err_init;
    logic [COORD_BITS:0]   su_inc_axial;
    logic [COORD_BITS+1:0] su_inc_diag;
    logic [COORD_BITS:0]   su_pixel_count;
    logic                  cmd_fire;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    slr_pkg::slr_status_t  status;

    // Register writes
    assign cfg.ready = 1'b1;

    always_comb
    begin
        dash_period_next = dash_period_reg;
        dash_on_next     = dash_on_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                slr_pkg::REG_DASH_PERIOD: dash_period_next = cfg.data;
                slr_pkg::REG_DASH_ON:     dash_on_next     = cfg.data;
                default:                  ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dash_period_reg <= slr_pkg::DASH_PERIOD_RST;
            dash_on_reg     <= slr_pkg::DASH_ON_RST;
        end
        else
        begin
            dash_period_reg <= dash_period_next;
            dash_on_reg     <= dash_on_next;
        end
    end

    // Line setup from the endpoints of the incoming beat
    slr_setup #(
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .start_x     (cmd.start_x),
        .start_y     (cmd.start_y),
        .end_x       (cmd.end_x),
        .end_y       (cmd.end_y),
        .step_x_neg  (su_x_neg),
        .step_y_neg  (su_y_neg),
        .x_major     (su_x_major),
        .err_init    (su_err_init),
        .inc_axial   (su_inc_axial),
        .inc_diag    (su_inc_diag),
        .pixel_count (su_pixel_count)
    );

    assign cmd_fire = cmd.valid && cmd.ready;

    // Pixel walker and output register
    slr_walker #(
        .COORD_BITS (COORD_BITS)
    ) u_walker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_fire        (cmd_fire),
        .in_action      (cmd.action),
        .in_start_x     (cmd.start_x),
        .in_start_y     (cmd.start_y),
        .in_style       (cmd.line_style),
        .in_ready       (cmd.ready),
        .su_step_x_neg  (su_x_neg),
        .su_step_y_neg  (su_y_neg),
        .su_x_major     (su_x_major),
        .su_err_init    (su_err_init),
        .su_inc_axial   (su_inc_axial),
        .su_inc_diag    (su_inc_diag),
        .su_pixel_count (su_pixel_count),
        .dash_period    (dash_period_reg),
        .dash_on_length (dash_on_reg),
        .out_ready      (pixel.ready),
        .out_valid      (pixel.valid),
        .out_x          (out_x),
        .out_y          (out_y),
        .out_visible    (pixel.visible),
        .out_last       (pixel.last_pixel),
        .status         (status)
    );

    assign pixel.pixel_x = out_x;
    assign pixel.pixel_y = out_y;

    // The command side stalls only behind a held pixel
    a_ready_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> (pixel.valid && !pixel.ready))
        else $error("command side stalled with no pixel held");

    // A start beat, or a step with no line, never raises a new pixel
    a_no_pixel_without_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.action == slr_pkg::ACT_START || status.step_idle))
        |=> !pixel.valid)
        else $error("pixel produced without an active step");

    // Once the final pixel is out, the line is finished
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.last_pixel) |-> !status.busy)
        else $error("line still busy after its final pixel");

    // A pixel beat taken with no new one loaded empties the output slot
    a_slot_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel.valid && pixel.ready && !(cmd_fire && cmd.action == slr_pkg::ACT_STEP))
        |=> !pixel.valid)
        else $error("output slot did not drain");

endmodule

// ----- verif/styled_line_rasterizer_tb.sv -----
// Self-checking testbench for the styled line rasterizer: pixels checked against a line walker.
module styled_line_rasterizer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CB          = 12;
    localparam int          HALF_PERIOD = 10;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          PHASES      = 7;
    // Style code with no meaning of its own; drawn as solid
    localparam logic [1:0]  STYLE_SPARE = 2'd3;

    typedef logic signed [CB-1:0] coord_t;
    typedef logic [CB-1:0]        span_t;
    typedef logic signed [CB+1:0] err_t;
    typedef logic [CB:0]          count_t;

    typedef struct packed {
        logic       action;
        coord_t     sx;
        coord_t     sy;
        coord_t     ex;
        coord_t     ey;
        logic [1:0] style;
    } line_cmd_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   vis;
        logic   last;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n;

    slr_cmd_if   #(.COORD_BITS(CB)) cmd_bus ();
    slr_pixel_if #(.COORD_BITS(CB)) pix_bus ();
    slr_cfg_if                      cfg_bus ();

    styled_line_rasterizer #(.COORD_BITS(CB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pixel (pix_bus),
        .cfg   (cfg_bus)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Line walker state, kept at the block's widths
    coord_t              walk_x;
    coord_t              walk_y;
    logic [CB-1:0]       span_x;
    logic [CB-1:0]       span_y;
    logic                back_x;
    logic                back_y;
    logic                x_leads;
    logic signed [CB+1:0] bres_err;
    logic [CB:0]         pixels_owed;
    logic [3:0]          pattern_pos;
    logic [1:0]          style_now;
    logic [3:0]          period_reg;
    logic [3:0]          dash_on_reg;

    line_cmd_t beats_to_send[$];
    pixel_t    pixels_due[$];
    line_cmd_t beat_out;

    int  beats_unsent;
    int  items_planned;
    int  idle_odds;
    int  send_hold;
    int  stall_left;
    bit  cmd_taken;
    int  quiet_cycles;
    int  mismatches;
    int  lines_started;
    int  pixels_checked;
    int  idle_steps;
    int  reg_writes;

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic reset_walker();
        walk_x      = '0;
        walk_y      = '0;
        span_x      = '0;
        span_y      = '0;
        back_x      = 1'b0;
        back_y      = 1'b0;
        x_leads     = 1'b0;
        bres_err    = '0;
        pixels_owed = '0;
        pattern_pos = '0;
        style_now   = slr_pkg::STYLE_SOLID;
        period_reg  = slr_pkg::DASH_PERIOD_RST;
        dash_on_reg = slr_pkg::DASH_ON_RST;
    endtask

    // Advance the walker by one accepted command beat
    task automatic walk_beat(input line_cmd_t c);
        int     dx;
        int     dy;
        int     major;
        int     minor;
        int     nxt;
        pixel_t p;
        if (c.action == slr_pkg::ACT_START) begin
            dx          = int'(c.ex) - int'(c.sx);
            dy          = int'(c.ey) - int'(c.sy);
            back_x      = dx < 0;
            back_y      = dy < 0;
            span_x      = span_t'((dx < 0) ? -dx : dx);
            span_y      = span_t'((dy < 0) ? -dy : dy);
            x_leads     = span_x > span_y;
            major       = x_leads ? int'(span_x) : int'(span_y);
            minor       = x_leads ? int'(span_y) : int'(span_x);
            walk_x      = c.sx;
            walk_y      = c.sy;
            bres_err    = err_t'(2 * minor - major);
            pixels_owed = count_t'(major + 1);
            pattern_pos = '0;
            style_now   = c.style;
            lines_started++;
        end
        else if (pixels_owed == 0) begin
            idle_steps++;
        end
        else begin
            major = x_leads ? int'(span_x) : int'(span_y);
            minor = x_leads ? int'(span_y) : int'(span_x);
            case (style_now)
                slr_pkg::STYLE_DOTTED: p.vis = ~pattern_pos[0];
                slr_pkg::STYLE_DASHED: p.vis = pattern_pos < dash_on_reg;
                default:               p.vis = 1'b1;
            endcase
            p.x    = walk_x;
            p.y    = walk_y;
            p.last = (pixels_owed == 1);
            pixels_due.push_back(p);
            // Plot first, then move along the line
            if (bres_err >= 0) begin
                if (x_leads)
                    walk_y = back_y ? coord_t'(walk_y - 1) : coord_t'(walk_y + 1);
                else
                    walk_x = back_x ? coord_t'(walk_x - 1) : coord_t'(walk_x + 1);
                bres_err = err_t'(int'(bres_err) + 2 * (minor - major));
            end
            else begin
                bres_err = err_t'(int'(bres_err) + 2 * minor);
            end
            if (x_leads)
                walk_x = back_x ? coord_t'(walk_x - 1) : coord_t'(walk_x + 1);
            else
                walk_y = back_y ? coord_t'(walk_y - 1) : coord_t'(walk_y + 1);
            nxt         = pattern_pos + 1;
            pattern_pos = (nxt >= period_reg) ? 4'd0 : nxt[3:0];
            pixels_owed = count_t'(pixels_owed - 1);
        end
    endtask

    // Start beat followed by a number of step beats with junk in the unused fields
    task automatic queue_line(input int sx, input int sy, input int ex, input int ey,
                              input logic [1:0] style, input int steps);
        line_cmd_t b;
        int        major;
        int        ax;
        int        ay;
        b.action = slr_pkg::ACT_START;
        b.sx     = coord_t'(sx);
        b.sy     = coord_t'(sy);
        b.ex     = coord_t'(ex);
        b.ey     = coord_t'(ey);
        b.style  = style;
        beats_to_send.push_back(b);
        for (int i = 0; i < steps; i++) begin
            b.action = slr_pkg::ACT_STEP;
            b.sx     = coord_t'($urandom);
            b.sy     = coord_t'($urandom);
            b.ex     = coord_t'($urandom);
            b.ey     = coord_t'($urandom);
            b.style  = 2'($urandom);
            beats_to_send.push_back(b);
        end
        ax            = (ex > sx) ? ex - sx : sx - ex;
        ay            = (ey > sy) ? ey - sy : sy - ey;
        major         = (ax > ay) ? ax : ay;
        beats_unsent  += steps + 1;
        items_planned += 1 + ((steps < major + 1) ? steps : major + 1);
    endtask

    // Mostly short lines walked to the end; some cut short, some overrun, a few huge
    task automatic queue_random_line();
        int         sx;
        int         sy;
        int         ex;
        int         ey;
        int         span;
        int         pick;
        int         major;
        int         steps;
        logic [1:0] style;
        pick  = $urandom_range(0, 99);
        span  = (pick < 70) ? 12 : ((pick < 94) ? 60 : 4095);
        sx    = int'($urandom_range(0, 4095)) - 2048;
        sy    = int'($urandom_range(0, 4095)) - 2048;
        ex    = sx + int'($urandom_range(0, 2 * span)) - span;
        ey    = sy + int'($urandom_range(0, 2 * span)) - span;
        ex    = (ex > 2047) ? 2047 : ((ex < -2048) ? -2048 : ex);
        ey    = (ey > 2047) ? 2047 : ((ey < -2048) ? -2048 : ey);
        major = (ex > sx) ? ex - sx : sx - ex;
        major = ((ey > sy ? ey - sy : sy - ey) > major) ? (ey > sy ? ey - sy : sy - ey)
                                                        : major;
        pick  = $urandom_range(0, 9);
        style = (pick < 3) ? slr_pkg::STYLE_SOLID : ((pick < 6) ? slr_pkg::STYLE_DOTTED :
                ((pick < 9) ? slr_pkg::STYLE_DASHED : STYLE_SPARE));
        pick  = $urandom_range(0, 99);
        if (major > 80)
            steps = $urandom_range(1, 30);
        else if (pick < 75)
            steps = major + 1;
        else if (pick < 88)
            steps = major + 1 + $urandom_range(1, 3);
        else
            steps = $urandom_range(0, major);
        queue_line(sx, sy, ex, ey, style, steps);
    endtask

    task automatic write_reg(input logic [slr_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [slr_pkg::CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // Hold off until every command has gone and every pixel has come back
    task automatic wait_drained();
        while (beats_unsent != 0 || pixels_due.size() != 0)
            @(negedge clk);
    endtask

    // Command driver
    always @(negedge clk) begin
        if (rst_n) begin
            if (!cmd_bus.valid || cmd_taken) begin
                if (send_hold > 0) begin
                    send_hold--;
                    cmd_bus.valid <= 1'b0;
                end
                else if (beats_to_send.size() != 0) begin
                    beat_out           = beats_to_send.pop_front();
                    cmd_bus.action     <= beat_out.action;
                    cmd_bus.start_x    <= beat_out.sx;
                    cmd_bus.start_y    <= beat_out.sy;
                    cmd_bus.end_x      <= beat_out.ex;
                    cmd_bus.end_y      <= beat_out.ey;
                    cmd_bus.line_style <= beat_out.style;
                    cmd_bus.valid      <= 1'b1;
                    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
                        send_hold = $urandom_range(1, 10);
                end
                else begin
                    cmd_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Pixel receiver with stall bursts
    always @(negedge clk) begin
        if (rst_n) begin
            if (stall_left > 0) begin
                stall_left--;
                pix_bus.ready <= 1'b0;
            end
            else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
                stall_left = $urandom_range(0, 9);
                pix_bus.ready <= 1'b0;
            end
            else begin
                pix_bus.ready <= 1'b1;
            end
        end
    end

    // Monitor: check pixels, track register writes, predict, watch for a hang
    always @(posedge clk) begin : watch
        pixel_t    got;
        pixel_t    want;
        line_cmd_t seen;
        logic      moved;
        if (rst_n) begin
            moved = 1'b0;
            if (pix_bus.valid && pix_bus.ready) begin
                moved    = 1'b1;
                got.x    = pix_bus.pixel_x;
                got.y    = pix_bus.pixel_y;
                got.vis  = pix_bus.visible;
                got.last = pix_bus.last_pixel;
                if (pixels_due.size() == 0) begin
                    note_mismatch($sformatf("unexpected pixel (%0d,%0d)", got.x, got.y));
                end
                else begin
                    want = pixels_due.pop_front();
                    pixels_checked++;
                    if (got.x !== want.x)
                        note_mismatch($sformatf("pixel_x %0d, want %0d", got.x, want.x));
                    if (got.y !== want.y)
                        note_mismatch($sformatf("pixel_y %0d, want %0d", got.y, want.y));
                    if (got.vis !== want.vis)
                        note_mismatch($sformatf("visible %b, want %b at (%0d,%0d)",
                                                got.vis, want.vis, want.x, want.y));
                    if (got.last !== want.last)
                        note_mismatch($sformatf("last_pixel %b, want %b at (%0d,%0d)",
                                                got.last, want.last, want.x, want.y));
                end
            end
            if (cfg_bus.valid && cfg_bus.ready) begin
                moved = 1'b1;
                reg_writes++;
                if (cfg_bus.index == slr_pkg::REG_DASH_PERIOD)
                    period_reg = cfg_bus.data;
                else if (cfg_bus.index == slr_pkg::REG_DASH_ON)
                    dash_on_reg = cfg_bus.data;
            end
            cmd_taken = cmd_bus.valid && cmd_bus.ready;
            if (cmd_taken) begin
                moved        = 1'b1;
                seen.action  = cmd_bus.action;
                seen.sx      = cmd_bus.start_x;
                seen.sy      = cmd_bus.start_y;
                seen.ex      = cmd_bus.end_x;
                seen.ey      = cmd_bus.end_y;
                seen.style   = cmd_bus.line_style;
                beats_unsent--;
                walk_beat(seen);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Stimulus and phase sequencing
    initial begin
        logic [3:0] period_set[PHASES];
        logic [3:0] on_set[PHASES];
        int         odds_set[PHASES];
        int         target;
        period_set = '{4'd10, 4'd1, 4'd15, 4'd0, 4'd7, 4'd3, 4'($urandom_range(1, 15))};
        on_set     = '{4'd5, 4'd0, 4'd15, 4'd1, 4'd3, 4'd15, 4'($urandom)};
        odds_set   = '{4, 3, 0, 6, 4, 10, 0};

        rst_n              = 1'b0;
        cmd_bus.valid      = 1'b0;
        cmd_bus.action     = slr_pkg::ACT_STEP;
        cmd_bus.start_x    = '0;
        cmd_bus.start_y    = '0;
        cmd_bus.end_x      = '0;
        cmd_bus.end_y      = '0;
        cmd_bus.line_style = slr_pkg::STYLE_SOLID;
        pix_bus.ready      = 1'b1;
        cfg_bus.valid      = 1'b0;
        cfg_bus.index      = '0;
        cfg_bus.data       = '0;
        beats_unsent       = 0;
        items_planned      = 0;
        idle_odds          = odds_set[0];
        send_hold          = 0;
        stall_left         = 0;
        cmd_taken          = 1'b0;
        quiet_cycles       = 0;
        mismatches         = 0;
        lines_started      = 0;
        pixels_checked     = 0;
        idle_steps         = 0;
        reg_writes         = 0;
        reset_walker();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed lines under the reset settings
        queue_line(0, 0, 0, 0, slr_pkg::STYLE_SOLID, 0);
        beats_to_send.delete();
        beats_unsent  = 0;
        items_planned = 0;
        begin
            line_cmd_t idle_step;
            idle_step = '{action: slr_pkg::ACT_STEP, sx: 12'h7ff, sy: 12'h800, ex: 12'h800,
                          ey: 12'h7ff, style: slr_pkg::STYLE_DASHED};
            // step with no line loaded
            beats_to_send.push_back(idle_step);
            beats_unsent++;
        end
        // single point, then a step past its end
        queue_line(0, 0, 0, 0, slr_pkg::STYLE_SOLID, 2);
        // x-major, leftwards and up, at the field extremes, with an overrun step
        queue_line(2047, -2048, 2044, -2046, slr_pkg::STYLE_DOTTED, 5);
        // full-range diagonal, cut off by the next start
        queue_line(-2048, 2047, 2047, -2048, slr_pkg::STYLE_DASHED, 3);
        // equal deltas walk y-major; spare style draws solid
        queue_line(-1, -1, -4, -4, STYLE_SPARE, 4);
        // y-major, leftwards and up
        queue_line(3, -2, 2, 1, slr_pkg::STYLE_DASHED, 4);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                wait_drained();
                repeat (4) @(negedge clk);
                idle_odds = odds_set[ph];
                write_reg(slr_pkg::REG_DASH_PERIOD, period_set[ph]);
                write_reg(slr_pkg::REG_DASH_ON, on_set[ph]);
                // index past the register map is ignored
                if (ph == 3 || ph == 5)
                    write_reg(4'($urandom_range(2, 15)), 4'($urandom));
                @(posedge clk);
            end
            target = items_planned + ((ph == 0) ? 100 : 120);
            while (items_planned < target)
                queue_random_line();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        while (pixels_due.size() != 0) begin
            want_left_report: begin
                pixel_t lost;
                lost = pixels_due.pop_front();
                note_mismatch($sformatf("pixel (%0d,%0d) never arrived", lost.x, lost.y));
            end
        end

        $display("covered %0d lines, %0d pixels checked, %0d steps with no line active",
                 lines_started, pixels_checked, idle_steps);
        $display("%0d register writes across %0d dash settings incl. period 0/1/15, on 0/15",
                 reg_writes, PHASES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- styled_line_rasterizer.f -----
rtl/core/slr_pkg.sv
rtl/core/slr_if.sv
rtl/core/slr_setup.sv
rtl/core/slr_walker.sv
rtl/core/styled_line_rasterizer.sv
verif/styled_line_rasterizer_tb.sv
